/* rtl/ssfc_pkg.sv */
// Shared types, codes, constants and operand decode functions of the sample format converter.
package ssfc_pkg;

  typedef enum logic [2:0] {
    MODE_F2I16      = 3'd0,
    MODE_I16_2F     = 3'd1,
    MODE_BF2F       = 3'd2,
    MODE_F2BF       = 3'd3,
    MODE_BF2I16     = 3'd4,
    MODE_I16_2BF    = 3'd5,
    MODE_I16_2BF_EG = 3'd6
  } mode_t;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_SCALE = 2'd1;
  localparam logic [1:0] CFG_GAIN  = 2'd2;

  localparam logic [31:0] ONE_BITS     = 32'h3F80_0000;
  localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

  typedef struct packed {
    logic               sign;
    logic signed [9:0]  exp;
    logic [23:0]        mant;
    logic               is_zero;
    logic               is_inf;
    logic               is_nan;
    logic [31:0]        bits;
  } fop_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic               last;
    logic               special;
    logic [31:0]        spec_bits;
    logic               sign;
    logic signed [9:0]  ea;
    logic signed [9:0]  eb;
    logic [23:0]        ma;
    logic [23:0]        mb;
  } s1_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic               last;
    logic [31:0]        bits;
  } prod_t;

  function automatic logic [4:0] lzc24(input logic [23:0] m);
    logic [4:0] cnt;
    logic       found;
    cnt   = 5'd0;
    found = 1'b0;
    for (int i = 23; i >= 0; i--) begin
      if (!found) begin
        if (m[i]) found = 1'b1;
        else cnt = cnt + 5'd1;
      end
    end
    return cnt;
  endfunction

  function automatic fop_t unpack_float(input logic [31:0] f);
    fop_t       r;
    logic [4:0] lz;
    r.sign    = f[31];
    r.bits    = f;
    r.is_zero = 1'b0;
    r.is_inf  = 1'b0;
    r.is_nan  = 1'b0;
    r.exp     = $signed({2'b00, f[30:23]});
    r.mant    = {1'b1, f[22:0]};
    lz        = lzc24({1'b0, f[22:0]});
    if (f[30:23] == 8'd0) begin
      r.is_zero = (f[22:0] == 23'd0);
      r.mant    = {1'b0, f[22:0]} << lz;
      r.exp     = 10'sd1 - $signed({5'b00000, lz});
    end else if (f[30:23] == 8'hFF) begin
      r.is_inf = (f[22:0] == 23'd0);
      r.is_nan = (f[22:0] != 23'd0);
    end
    return r;
  endfunction

  function automatic fop_t unpack_int16(input logic [15:0] v);
    fop_t        r;
    logic [15:0] mag;
    logic [4:0]  lz;
    mag       = v[15] ? (16'd0 - v) : v;
    lz        = lzc24({mag, 8'd0});
    r.sign    = v[15];
    r.bits    = 32'd0;
    r.is_zero = (mag == 16'd0);
    r.is_inf  = 1'b0;
    r.is_nan  = 1'b0;
    r.mant    = {mag, 8'd0} << lz;
    r.exp     = 10'sd142 - $signed({5'b00000, lz});
    return r;
  endfunction

endpackage

/* rtl/ssfc_in_if.sv */
// Input channel of the sample format converter.
interface ssfc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_in;
  logic [31:0] elem_gain;
  logic        last_in;
  modport source(output valid, sample_in, elem_gain, last_in, input ready);
  modport sink(input valid, sample_in, elem_gain, last_in, output ready);
endinterface

/* rtl/ssfc_out_if.sv */
// Result channel of the sample format converter.
interface ssfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_out;
  logic        last_out;
  modport source(output valid, sample_out, last_out, input ready);
  modport sink(input valid, sample_out, last_out, output ready);
endinterface

/* rtl/ssfc_unpack.sv */
// Operand selection, decode, normalization and special-value handling.
module ssfc_unpack (
  input  logic [2:0]     mode,
  input  logic [31:0]    scale_bits,
  input  logic [31:0]    gain_bits,
  input  logic [31:0]    sample_in,
  input  logic [31:0]    elem_gain,
  input  logic           last_in,
  output ssfc_pkg::s1_t  s1
);
  import ssfc_pkg::*;

  fop_t a;
  fop_t b;
  logic sgn;

  always_comb begin
    a = unpack_float(sample_in);
    b = unpack_float(scale_bits);
    case (mode)
      MODE_BF2I16: begin
        a = unpack_float({sample_in[15:0], 16'd0});
      end
      MODE_I16_2F, MODE_I16_2BF: begin
        a = unpack_int16(sample_in[15:0]);
        b = unpack_float(gain_bits);
      end
      MODE_I16_2BF_EG: begin
        a = unpack_int16(sample_in[15:0]);
        b = unpack_float(elem_gain);
      end
      default: begin
      end
    endcase
  end

  assign sgn = a.sign ^ b.sign;

  always_comb begin
    s1.mode      = mode;
    s1.last      = last_in;
    s1.sign      = sgn;
    s1.ea        = a.exp;
    s1.eb        = b.exp;
    s1.ma        = a.mant;
    s1.mb        = b.mant;
    s1.special   = 1'b1;
    s1.spec_bits = 32'd0;
    case (mode)
      MODE_BF2F: s1.spec_bits = {sample_in[15:0], 16'd0};
      MODE_F2BF: s1.spec_bits = sample_in;
      MODE_F2I16, MODE_I16_2F, MODE_BF2I16, MODE_I16_2BF, MODE_I16_2BF_EG: begin
        if (a.is_nan) begin
          s1.spec_bits = a.bits | QUIET_BIT;
        end else if (b.is_nan) begin
          s1.spec_bits = b.bits | QUIET_BIT;
        end else if ((a.is_inf && b.is_zero) || (a.is_zero && b.is_inf)) begin
          s1.spec_bits = QNAN_DEFAULT;
        end else if (a.is_inf || b.is_inf) begin
          s1.spec_bits = {sgn, 8'hFF, 23'd0};
        end else if (a.is_zero || b.is_zero) begin
          s1.spec_bits = {sgn, 31'd0};
        end else begin
          s1.special = 1'b0;
        end
      end
      default: s1.spec_bits = 32'd0;
    endcase
  end

endmodule

/* rtl/ssfc_mul.sv */
// Three-stage float32 multiplier: mantissa product, normalize and denormalize, round and pack.
module ssfc_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  ssfc_pkg::s1_t   s1,
  output logic            out_valid,
  output ssfc_pkg::prod_t prod
);
  import ssfc_pkg::*;

  logic               v2_r, v3_r, v4_r;
  logic [2:0]         mode2_r, mode3_r;
  logic               last2_r, last3_r;
  logic               sp2_r, sp3_r;
  logic [31:0]        spb2_r, spb3_r;
  logic               sign2_r, sign3_r;
  logic [47:0]        p2_r;
  logic signed [10:0] esum2_r;
  logic [23:0]        m3_r;
  logic               g3_r, st3_r, ovf3_r;
  logic [7:0]         base3_r;
  prod_t              prod_r;

  logic [47:0]        p_nxt;
  logic signed [10:0] esum_nxt;
  logic [47:0]        norm;
  logic signed [10:0] eres;
  logic signed [10:0] sh_full;
  logic [4:0]         sh;
  logic [47:0]        shifted;
  logic [47:0]        mask;
  logic [7:0]         base_nxt;
  logic               rnd;
  logic [24:0]        m25;
  logic [30:0]        mag;
  logic [31:0]        bits_nxt;

  assign p_nxt    = s1.ma * s1.mb;
  assign esum_nxt = {s1.ea[9], s1.ea} + {s1.eb[9], s1.eb};

  always_comb begin
    if (p2_r[47]) begin
      norm = p2_r;
      eres = esum2_r - 11'sd126;
    end else begin
      norm = {p2_r[46:0], 1'b0};
      eres = esum2_r - 11'sd127;
    end
    sh_full = 11'sd1 - eres;
    if (eres >= 11'sd1) sh = 5'd0;
    else if (sh_full > 11'sd31) sh = 5'd31;
    else sh = sh_full[4:0];
    shifted  = norm >> sh;
    mask     = (48'd1 << sh) - 48'd1;
    base_nxt = (eres >= 11'sd1) ? 8'(eres - 11'sd1) : 8'd0;
  end

  always_comb begin
    rnd = g3_r & (st3_r | m3_r[0]);
    m25 = {1'b0, m3_r} + {24'd0, rnd};
    mag = {base3_r, 23'd0} + {6'd0, m25};
    if (sp3_r) bits_nxt = spb3_r;
    else if (ovf3_r) bits_nxt = {sign3_r, 8'hFF, 23'd0};
    else bits_nxt = {sign3_r, mag};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v2_r <= in_valid;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode2_r <= s1.mode;
      last2_r <= s1.last;
      sp2_r   <= s1.special;
      spb2_r  <= s1.spec_bits;
      sign2_r <= s1.sign;
      p2_r    <= p_nxt;
      esum2_r <= esum_nxt;

      mode3_r <= mode2_r;
      last3_r <= last2_r;
      sp3_r   <= sp2_r;
      spb3_r  <= spb2_r;
      sign3_r <= sign2_r;
      m3_r    <= shifted[47:24];
      g3_r    <= shifted[23];
      st3_r   <= (|shifted[22:0]) | (|(norm & mask));
      base3_r <= base_nxt;
      ovf3_r  <= (eres >= 11'sd255);

      prod_r.mode <= mode3_r;
      prod_r.last <= last3_r;
      prod_r.bits <= bits_nxt;
    end
  end

  assign out_valid = v4_r;
  assign prod      = prod_r;

endmodule

/* rtl/ssfc_format.sv */
// Output formatting: float32 to int16 with rounding and saturation, float32 to bfloat16.
module ssfc_format (
  input  ssfc_pkg::prod_t prod,
  output logic [31:0]     result
);
  import ssfc_pkg::*;

  function automatic logic [15:0] to_int16(input logic [31:0] f);
    logic [23:0] mant;
    logic [7:0]  shv;
    logic [4:0]  sh;
    logic [23:0] t;
    logic [23:0] rb;
    logic [15:0] t16;
    logic [15:0] r;
    mant = {f[30:23] != 8'd0, f[22:0]};
    shv  = 8'd150 - f[30:23];
    sh   = shv[4:0];
    t    = mant >> sh;
    rb   = mant >> (sh - 5'd1);
    t16  = t[15:0] + {15'd0, rb[0]};
    if (f[30:23] == 8'hFF && f[22:0] != 23'd0) r = 16'd0;
    else if (f[30:23] >= 8'd142) r = f[31] ? 16'h8000 : 16'h7FFF;
    else if (f[30:23] < 8'd126) r = 16'd0;
    else if (f[31]) r = 16'd0 - t16;
    else if (t16 > 16'h7FFF) r = 16'h7FFF;
    else r = t16;
    return r;
  endfunction

  function automatic logic [15:0] to_bf16(input logic [31:0] f);
    logic [31:0] s;
    logic [15:0] r;
    s = f + 32'h0000_7FFF + {31'd0, f[16]};
    if (f[30:23] == 8'hFF && f[22:0] != 23'd0) r = f[31:16] | QUIET_BIT[31:16] >> 0 | 16'h0040;
    else r = s[31:16];
    return r;
  endfunction

  always_comb begin
    case (prod.mode)
      MODE_F2I16, MODE_BF2I16:                 result = {16'd0, to_int16(prod.bits)};
      MODE_I16_2F, MODE_BF2F:                  result = prod.bits;
      MODE_F2BF, MODE_I16_2BF, MODE_I16_2BF_EG: result = {16'd0, to_bf16(prod.bits)};
      default:                                 result = 32'd0;
    endcase
  end

endmodule

/* rtl/scaled_sample_format_converter.sv */
// Top level of the scaled sample format converter: configuration, input stage and output register.
// The converter accepts one sample per cycle. Operand decode, mantissa multiply,
// normalize, round and pack, and output formatting each take one register stage
// between a transfer in and its result. The whole pipeline advances together
// whenever the output register is empty or its result is taken, so a stall on the
// result channel holds every stage and stops input transfers in the same cycle.
module scaled_sample_format_converter (
  input  logic        clk,
  input  logic        rst_n,
  ssfc_in_if.sink     in_s,
  ssfc_out_if.source  out_s,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import ssfc_pkg::*;

  logic [2:0]  mode_r;
  logic [31:0] scale_r;
  logic [31:0] gain_r;
  logic        en;
  s1_t         s1_nxt;
  s1_t         s1_r;
  logic        v1_r;
  logic        pv;
  prod_t       prod;
  logic [31:0] result;
  logic        ov_r;
  logic [31:0] sample_out_r;
  logic        last_out_r;

  assign en         = !ov_r || out_s.ready;
  assign in_s.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_F2I16;
      scale_r <= ONE_BITS;
      gain_r  <= ONE_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_data[2:0];
        CFG_SCALE: scale_r <= cfg_data;
        CFG_GAIN:  gain_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ssfc_unpack u_unpack (
    .mode       (mode_r),
    .scale_bits (scale_r),
    .gain_bits  (gain_r),
    .sample_in  (in_s.sample_in),
    .elem_gain  (in_s.elem_gain),
    .last_in    (in_s.last_in),
    .s1         (s1_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_s.valid;
      ov_r <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r         <= s1_nxt;
      sample_out_r <= result;
      last_out_r   <= prod.last;
    end
  end

  ssfc_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v1_r),
    .s1        (s1_r),
    .out_valid (pv),
    .prod      (prod)
  );

  ssfc_format u_format (
    .prod   (prod),
    .result (result)
  );

  assign out_s.valid      = ov_r;
  assign out_s.sample_out = sample_out_r;
  assign out_s.last_out   = last_out_r;

endmodule
